[hdl/ufrt_pkg.sv]
// Package for the fragment reorder window tracker.
// Holds sizes, status codes and the controller/datapath command struct.
package ufrt_pkg;
	localparam int WindowSlots  = 16;
	localparam int SlotW        = 4;
	localparam int MaxFragments = 256;
	localparam int MaxPayload   = 1472;
	localparam int OffW         = 19;
	localparam int CountW       = 9;

	localparam logic [1:0] StatDispatch = 2'd0;
	localparam logic [1:0] StatBuffer   = 2'd1;
	localparam logic [1:0] StatReady    = 2'd2;

	typedef struct packed {
		logic [31:0] session;
		logic [31:0] sequence_req;
		logic [7:0]  fragment_index;
		logic [7:0]  last_fragment;
		logic [10:0] payload_bytes;
	} hdr_t;

	typedef struct packed {
		logic [1:0]      status;
		logic            store_payload;
		logic [SlotW-1:0] slot;
		logic [OffW-1:0] byte_offset;
		logic            duplicate;
		logic            gap_seen;
		logic            session_changed;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture header, run window step
		logic record;  // run fragment record step
	} cmd_t;
endpackage

[hdl/ufrt_if.sv]
// Valid/ready channel interface for the tracker.
// Depends on ufrt_pkg for the hdr_t and res_t payload types.
interface ufrt_hdr_if;
	import ufrt_pkg::*;
	logic valid;
	logic ready;
	hdr_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ufrt_res_if;
	import ufrt_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/udp_fragment_reorder_tracker_top.sv]
// Top level of the fragment reorder window tracker.
// Depends on ufrt_pkg, ufrt_if, ufrt_ctrl, ufrt_dp.
//
// channel  role  payload
// hdr      sink  session, sequence_req, fragment_index, last_fragment, payload_bytes
// res      src   status, store_payload, slot, byte_offset, duplicate, gap_seen,
//               session_changed
//
// A transaction runs through accept with window step, then fragment record, then
// result shown. The result register holds until taken; the next header is
// accepted the cycle after. Reset clears all window state at once.
module udp_fragment_reorder_tracker_top import ufrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	ufrt_hdr_if.sink hdr,
	ufrt_res_if.source res
);
	cmd_t cmd;

	ufrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(hdr.valid), .in_ready(hdr.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.cmd(cmd)
	);

	ufrt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .hdr(hdr.data), .res(res.data)
	);
endmodule

[hdl/ufrt_ctrl.sv]
// Controller: sequences header accept, window step, record step and output.
// Depends on ufrt_pkg.
module ufrt_ctrl import ufrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);
	typedef enum logic [1:0] {S_IDLE, S_REC, S_OUT} state_t;
	state_t state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.record = (state_q == S_REC);

	// advance through the accept and record steps, hold until the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_REC;
				S_REC:  state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[hdl/ufrt_dp.sv]
// Datapath: window state, slot arrays and result register.
// Depends on ufrt_pkg; driven by cmd_t from ufrt_ctrl.
module ufrt_dp import ufrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  hdr_t hdr,
	output res_t res
);
	logic [31:0] cur_session_q, exp_seq_q;
	logic [WindowSlots-1:0] ready_q;
	logic [CountW-1:0] count_q [WindowSlots];
	logic [MaxFragments-1:0] seen_q [WindowSlots];
	logic [OffW-1:0] size_q [WindowSlots];
	hdr_t hdr_q;
	logic skip_q;  // dispatched; no record step
	res_t res_q;

	// window step, computed from the incoming header
	logic [31:0] exp_eff, wdist, next_seq;
	logic changed, disp, gap, ahead;
	logic [WindowSlots-1:0] keep, clr;
	logic [SlotW-1:0] islot;
	logic run;

	always_comb begin
		changed = hdr.session != cur_session_q;
		exp_eff = changed ? hdr.sequence_req : exp_seq_q;
		islot   = hdr.sequence_req[SlotW-1:0];
		disp    = (hdr.sequence_req == exp_eff) && (hdr.last_fragment == 8'd0);
		wdist   = hdr.sequence_req - exp_eff;
		gap     = !disp && (wdist >= 32'(WindowSlots));
		ahead   = wdist == 32'(WindowSlots);
		// leading ready run from the top sequence down
		run = 1'b1;
		next_seq = hdr.sequence_req;
		keep = '0;
		for (int k = 0; k < WindowSlots; k++) begin
			logic [31:0] s;
			s = exp_eff + 32'(WindowSlots - 1 - k);
			if (run && ready_q[s[SlotW-1:0]]) begin
				keep[s[SlotW-1:0]] = 1'b1;
				next_seq = s;
			end else begin
				run = 1'b0;
			end
		end
		clr = '0;
		if (disp) clr[islot] = 1'b1;
		else if (gap) clr = ahead ? ~keep : '1;
	end

	// record step on the captured header
	logic [31:0] rdist;
	logic [OffW-1:0] off_s1;
	logic [CountW-1:0] cnt_n;
	logic hit, inwin;
	logic [SlotW-1:0] rs;
	always_comb begin
		rs     = hdr_q.sequence_req[SlotW-1:0];
		rdist  = hdr_q.sequence_req - exp_seq_q;
		inwin  = !skip_q && (rdist < 32'(WindowSlots));
		hit    = seen_q[rs][hdr_q.fragment_index];
		off_s1 = OffW'(32'(hdr_q.fragment_index) * 32'(MaxPayload));
		cnt_n  = count_q[rs] + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_session_q <= '0;
			exp_seq_q <= '0;
			ready_q <= '0;
			skip_q <= 1'b0;
			for (int i = 0; i < WindowSlots; i++) begin
				count_q[i] <= '0;
				seen_q[i] <= '0;
				size_q[i] <= '0;
			end
		end else if (cmd.load) begin
			hdr_q <= hdr;
			skip_q <= disp;
			cur_session_q <= hdr.session;
			exp_seq_q <= disp ? exp_eff + 32'd1 :
				!gap ? exp_eff : ahead ? next_seq : hdr.sequence_req;
			for (int i = 0; i < WindowSlots; i++) begin
				if (clr[i]) begin
					ready_q[i] <= 1'b0;
					count_q[i] <= '0;
					seen_q[i] <= '0;
					size_q[i] <= '0;
				end
			end
			res_q.status <= disp ? StatDispatch : StatBuffer;
			res_q.store_payload <= 1'b0;
			res_q.slot <= islot;
			res_q.byte_offset <= '0;
			res_q.duplicate <= 1'b0;
			res_q.gap_seen <= gap;
			res_q.session_changed <= changed;
		end else if (cmd.record && inwin) begin
			if (hit) begin
				res_q.duplicate <= 1'b1;
			end else begin
				seen_q[rs][hdr_q.fragment_index] <= 1'b1;
				res_q.store_payload <= 1'b1;
				res_q.byte_offset <= off_s1;
				if (hdr_q.fragment_index == hdr_q.last_fragment)
					size_q[rs] <= off_s1 + OffW'(hdr_q.payload_bytes);
				count_q[rs] <= cnt_n;
				if (cnt_n == {1'b0, hdr_q.last_fragment} + 9'd1) begin
					ready_q[rs] <= 1'b1;
					if (rdist == 32'd0) res_q.status <= StatReady;
				end
			end
		end
	end

	assign res = res_q;
endmodule
